FILE: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Heap geometry, header word layout, result codes and sequencer states.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int LEN_W      = $clog2(HEAP_WORDS + 1);
  localparam int SUM_W      = LEN_W + 1;
  localparam int HDR_W      = LEN_W + 1;
  localparam int BYTES_W    = 16;
  localparam int INDEX_W    = 12;
  localparam int NEED_W     = BYTES_W - 1;
  localparam int WIDE_W     = NEED_W + 1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_ZERO = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HDR,
    S_MERGE,
    S_FIT,
    S_SPLIT,
    S_CHECK,
    S_FINISH
  } state_t;

endpackage

FILE: design/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit block allocator unit
// Allocates and releases blocks of one word heap kept as a chain of headers.
// ----------------------------------------------------------------------------
// After reset the unit clears its header memory, one word per cycle, over
// all HEAP_WORDS (4096) words before it takes the first request. A zero-size
// allocate and a release of index 0 finish without reading the heap, and any
// other release first reads and checks its header. An allocate walks the
// headers from word 0, steps over every used header, merges each free block
// that it reaches with the free blocks behind it, up to a header that cannot
// be merged or the heap end, tests whether the merged block fits, and splits
// the found block when enough is left over. The single header memory returns
// one header per cycle. One request is worked on at a time; a finished result
// waits in the output register while the next request is taken, and a
// request that finishes while that result is still stalled waits until it is
// accepted.
module first_fit_block_allocator_unit
  import ffba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic [INDEX_W-1:0] release_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [INDEX_W-1:0] payload_index
);

  logic [HDR_W-1:0]  mem [HEAP_WORDS];
  logic [HDR_W-1:0]  rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HDR_W-1:0]  wr_data;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  clr, clr_next;
  logic [SUM_W-1:0]   pos, pos_next;
  logic [SUM_W-1:0]   size, size_next;
  logic [NEED_W-1:0]  need, need_next;
  status_t            res_status, res_status_next;
  logic [INDEX_W-1:0] res_index, res_index_next;
  logic               out_load;

  logic              hdr_free;
  logic [LEN_W-1:0]  hdr_len;
  logic [SUM_W-1:0]  hop;
  logic [SUM_W-1:0]  size_sum;
  logic [SUM_W-1:0]  merge_end;
  logic [SUM_W-1:0]  walk_end;
  logic [WIDE_W-1:0] split_at;
  logic              fits;
  logic              whole;

  assign hdr_free  = rdata[LEN_W];
  assign hdr_len   = rdata[LEN_W-1:0];
  assign hop       = pos + SUM_W'(hdr_len);
  assign size_sum  = size + SUM_W'(hdr_len);
  assign merge_end = pos + size_sum;
  assign walk_end  = pos + size;
  assign split_at  = WIDE_W'(pos) + WIDE_W'(need);
  assign fits      = NEED_W'(size) >= need;
  assign whole     = (NEED_W'(size) <= need + 1'b1) ||
                     (split_at + 1'b1 >= WIDE_W'(HEAP_WORDS));

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    size       <= size_next;
    need       <= need_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    if (out_load) begin
      status        <= res_status;
      payload_index <= res_index;
    end
  end

  always_comb begin
    state_next      = state;
    clr_next        = clr;
    pos_next        = pos;
    size_next       = size;
    need_next       = need;
    res_status_next = res_status;
    res_index_next  = res_index;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = pos[ADDR_W-1:0];
    wr_data         = '0;

    unique case (state)
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = (clr == '0) ? {1'b1, LEN_W'(HEAP_WORDS)} : '0;
        clr_next = clr + 1'b1;
        if (clr == ADDR_W'(HEAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_ALLOC) begin
            if (request_bytes == '0) begin
              res_status_next = ST_ZERO;
              res_index_next  = '0;
              state_next      = S_FINISH;
            end else begin
              need_next  = NEED_W'(request_bytes[BYTES_W-1:2]) +
                           NEED_W'(|request_bytes[1:0]) + 1'b1;
              pos_next   = '0;
              rd_addr    = '0;
              state_next = S_HDR;
            end
          end else begin
            if ((release_index == '0) ||
                (SUM_W'(release_index) >= SUM_W'(HEAP_WORDS))) begin
              res_status_next = ST_BAD;
              res_index_next  = '0;
              state_next      = S_FINISH;
            end else begin
              pos_next   = SUM_W'(release_index) - 1'b1;
              rd_addr    = ADDR_W'(SUM_W'(release_index) - 1'b1);
              state_next = S_CHECK;
            end
          end
        end
      end

      S_HDR: begin
        if (!hdr_free) begin
          if (hdr_len == '0) begin
            res_status_next = ST_OOM;
            res_index_next  = '0;
            state_next      = S_FINISH;
          end else if (hop >= SUM_W'(HEAP_WORDS)) begin
            res_status_next = ST_OOM;
            res_index_next  = '0;
            state_next      = S_FINISH;
          end else begin
            pos_next = hop;
            rd_addr  = hop[ADDR_W-1:0];
          end
        end else if (hdr_len == '0) begin
          res_status_next = ST_OOM;
          res_index_next  = '0;
          state_next      = S_FINISH;
        end else begin
          size_next = SUM_W'(hdr_len);
          if (hop < SUM_W'(HEAP_WORDS)) begin
            rd_addr    = hop[ADDR_W-1:0];
            state_next = S_MERGE;
          end else begin
            state_next = S_FIT;
          end
        end
      end

      S_MERGE: begin
        if (hdr_free && (hdr_len != '0)) begin
          size_next = size_sum;
          wr_en     = 1'b1;
          wr_data   = {1'b1, LEN_W'(size_sum)};
          if (merge_end < SUM_W'(HEAP_WORDS)) begin
            rd_addr = merge_end[ADDR_W-1:0];
          end else begin
            state_next = S_FIT;
          end
        end else begin
          state_next = S_FIT;
        end
      end

      S_FIT: begin
        if (fits) begin
          if (whole) begin
            wr_en           = 1'b1;
            wr_data         = {1'b0, LEN_W'(size)};
            res_status_next = ST_OK;
            res_index_next  = INDEX_W'(pos + 1'b1);
            state_next      = S_FINISH;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = split_at[ADDR_W-1:0];
            wr_data    = {1'b1, LEN_W'(NEED_W'(size) - need)};
            state_next = S_SPLIT;
          end
        end else if (walk_end >= SUM_W'(HEAP_WORDS)) begin
          res_status_next = ST_OOM;
          res_index_next  = '0;
          state_next      = S_FINISH;
        end else begin
          pos_next   = walk_end;
          rd_addr    = walk_end[ADDR_W-1:0];
          state_next = S_HDR;
        end
      end

      S_SPLIT: begin
        wr_en           = 1'b1;
        wr_data         = {1'b0, LEN_W'(need)};
        res_status_next = ST_OK;
        res_index_next  = INDEX_W'(pos + 1'b1);
        state_next      = S_FINISH;
      end

      S_CHECK: begin
        res_index_next = '0;
        if (hdr_free || (hdr_len == '0)) begin
          res_status_next = ST_BAD;
        end else begin
          wr_en           = 1'b1;
          wr_data         = {1'b1, hdr_len};
          res_status_next = ST_OK;
        end
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/first_fit_block_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// First-fit block allocator unit testbench
// Drives allocate and release requests through the valid/stall handshake,
// predicts every result with a header-level model of the heap, and compares
// each accepted result against the oldest prediction. A directed table comes
// first, followed by random traffic with bursty input and a patterned output
// stall.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit_tb;
  import ffba_pkg::*;

  localparam int RANDOM_ITEMS   = 1525;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 40_000_000;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct {
    kind_t              kind;
    logic [BYTES_W-1:0] bytes;
    logic [INDEX_W-1:0] index;
    bit                 typed;
    status_t            exp_status;
    logic [INDEX_W-1:0] exp_index;
  } heap_request_t;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] index;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = 1'b0;
  logic [BYTES_W-1:0] request_bytes = '0;
  logic [INDEX_W-1:0] release_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [INDEX_W-1:0] payload_index;

  bit                 block_free [HEAP_WORDS];
  bit [LEN_W-1:0]     block_len [HEAP_WORDS];
  heap_result_t       awaited_results [$];
  logic [INDEX_W-1:0] live_payloads [$];
  logic [INDEX_W-1:0] last_released = '0;
  int                 failures = 0;
  int                 cycle_count = 0;
  int                 burst_left = 8;
  logic               holdoff_req = 1'b0;

  heap_request_t directed_rows [DIRECTED_ROWS] = '{
    '{KIND_ALLOC,   16'd0,     12'd0,    1'b1, ST_ZERO, 12'd0},
    '{KIND_ALLOC,   16'd1,     12'd0,    1'b1, ST_OK,   12'd1},
    '{KIND_RELEASE, 16'd0,     12'd0,    1'b1, ST_BAD,  12'd0},
    '{KIND_RELEASE, 16'd0,     12'd4095, 1'b1, ST_BAD,  12'd0},
    '{KIND_ALLOC,   16'd65535, 12'd0,    1'b1, ST_OOM,  12'd0},
    '{KIND_ALLOC,   16'd4,     12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b1, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b1, ST_BAD,  12'd0},
    '{KIND_ALLOC,   16'd5,     12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_ALLOC,   16'd16380, 12'd0,    1'b1, ST_OOM,  12'd0},
    '{KIND_ALLOC,   16'd8,     12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_ALLOC,   16'd4,     12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd3,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd5,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd8,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b0, ST_OK,   12'd0},
    '{KIND_ALLOC,   16'd16376, 12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b0, ST_OK,   12'd0},
    '{KIND_ALLOC,   16'd16380, 12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b0, ST_OK,   12'd0},
    '{KIND_ALLOC,   16'd16372, 12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b0, ST_OK,   12'd0},
    '{KIND_ALLOC,   16'd16368, 12'd0,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd1,    1'b0, ST_OK,   12'd0},
    '{KIND_RELEASE, 16'd0,     12'd2048, 1'b1, ST_BAD,  12'd0}
  };

  first_fit_block_allocator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .request_bytes (request_bytes),
    .release_index (release_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_index (payload_index)
  );

  always #5 clk = ~clk;

  function automatic void clear_heap();
    for (int i = 0; i < HEAP_WORDS; i++) begin
      block_free[i] = 1'b0;
      block_len[i]  = '0;
    end
    block_free[0] = 1'b1;
    block_len[0]  = LEN_W'(HEAP_WORDS);
  endfunction

  function automatic heap_result_t first_fit_allocate(input logic [BYTES_W-1:0] bytes);
    heap_result_t r;
    int need;
    int pos;
    int size;
    int nxt;
    bit found;
    r.status = ST_OK;
    r.index  = '0;
    pos      = 0;
    size     = 0;
    found    = 1'b0;
    if (bytes == '0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = (int'(bytes) + 3) / 4 + 1;
    while (pos < HEAP_WORDS) begin
      if (!block_free[pos]) begin
        if (block_len[pos] == '0) break;
        pos += int'(block_len[pos]);
        continue;
      end
      size = int'(block_len[pos]);
      if (size == 0) break;
      nxt = pos + size;
      while (nxt < HEAP_WORDS && block_free[nxt] && block_len[nxt] != '0) begin
        size += int'(block_len[nxt]);
        block_len[pos] = LEN_W'(size);
        nxt = pos + size;
      end
      if (size >= need) begin
        found = 1'b1;
        break;
      end
      pos += size;
    end
    if (!found) begin
      r.status = ST_OOM;
      return r;
    end
    if (size <= need + 1 || pos + need + 1 >= HEAP_WORDS) begin
      block_free[pos] = 1'b0;
    end else begin
      block_free[pos + need] = 1'b1;
      block_len[pos + need]  = LEN_W'(size - need);
      block_free[pos]        = 1'b0;
      block_len[pos]         = LEN_W'(need);
    end
    r.index = INDEX_W'(pos + 1);
    return r;
  endfunction

  function automatic heap_result_t header_release(input logic [INDEX_W-1:0] index);
    heap_result_t r;
    int hdr;
    r.status = ST_BAD;
    r.index  = '0;
    if (index == '0 || int'(index) >= HEAP_WORDS) return r;
    hdr = int'(index) - 1;
    if (block_free[hdr] || block_len[hdr] == '0) return r;
    block_free[hdr] = 1'b1;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic void log_accepted(input heap_request_t req);
    heap_result_t r;
    if (req.kind == KIND_ALLOC) begin
      r = first_fit_allocate(req.bytes);
      if (r.status == ST_OK) live_payloads.push_back(r.index);
    end else begin
      r = header_release(req.index);
      if (r.status == ST_OK) begin
        last_released = req.index;
        foreach (live_payloads[i]) begin
          if (live_payloads[i] == req.index) begin
            live_payloads.delete(i);
            break;
          end
        end
      end
    end
    if (req.typed) begin
      r.status = req.exp_status;
      r.index  = req.exp_index;
    end
    awaited_results.push_back(r);
  endfunction

  function automatic heap_request_t random_request();
    heap_request_t req;
    int pick;
    req.typed      = 1'b0;
    req.exp_status = ST_OK;
    req.exp_index  = '0;
    req.bytes      = BYTES_W'($urandom);
    req.index      = INDEX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.kind = KIND_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 3) req.bytes = '0;
      else if (pick < 65) req.bytes = BYTES_W'($urandom_range(1, 64));
      else if (pick < 88) req.bytes = BYTES_W'($urandom_range(65, 512));
      else if (pick < 96) req.bytes = BYTES_W'($urandom_range(513, 4096));
      else req.bytes = BYTES_W'($urandom_range(4097, 65535));
    end else begin
      req.kind = KIND_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 80 && live_payloads.size() != 0)
        req.index = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
      else if (pick < 88)
        req.index = last_released;
    end
    return req;
  endfunction

  task automatic offer(input heap_request_t req);
    in_valid      <= 1'b1;
    kind          <= req.kind;
    request_bytes <= req.bytes;
    release_index <= req.index;
    do @(posedge clk); while (in_stall);
    log_accepted(req);
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 20);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clear_heap();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      offer(directed_rows[i]);
      pace();
    end
    wait_for_results();
    @(posedge clk);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 60) holdoff_req <= 1'b1;
      if (n % 400 == 399) begin
        wait_for_results();
        @(posedge clk);
      end
      offer(random_request());
      pace();
    end
    wait_for_results();
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  int  stall_mode = 0;
  int  mode_left = 0;
  int  holdoff_left = 0;
  bit  holdoff_taken = 1'b0;

  always @(posedge clk) begin
    if (holdoff_req && !holdoff_taken) begin
      holdoff_taken = 1'b1;
      holdoff_left  = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_count[2];
      endcase
    end
  end

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: status %0d payload_index %0d",
               status, payload_index);
        failures++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status);
          failures++;
        end
        if (payload_index !== exp_r.index) begin
          $error("payload_index: expected %0d, actual %0d", exp_r.index, payload_index);
          failures++;
        end
      end
    end
  end

endmodule
